FILE: rtl/core/hpd_pkg.sv
// ----------------------------------------------------------------------------
// hpd_pkg
// Types, status codes and canonical code tables for the HPACK Huffman decoder.
// ----------------------------------------------------------------------------
package hpd_pkg;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic     vld;
    in_item_t item;
  } fifo_head_t;

  localparam logic [1:0] ST_SYMBOL   = 2'd0;
  localparam logic [1:0] ST_END_OK   = 2'd1;
  localparam logic [1:0] ST_BAD_CODE = 2'd2;
  localparam logic [1:0] ST_BAD_PAD  = 2'd3;

  localparam int          CODE_W   = 30;
  localparam logic [4:0]  MAX_LEN  = 5'd30;
  localparam logic [4:0]  PAD_MAX  = 5'd7;

  typedef logic [CODE_W-1:0] code_tab_t [32];
  typedef logic [8:0]        base_tab_t [32];
  typedef logic [7:0]        sym_tab_t  [256];
  typedef logic [CODE_W-1:0] rom_code_t [256];
  typedef logic [4:0]        rom_len_t  [256];

  localparam rom_code_t ROM_CODE = '{
    30'h1ff8, 30'h7fffd8, 30'hfffffe2, 30'hfffffe3, 30'hfffffe4,
    30'hfffffe5, 30'hfffffe6, 30'hfffffe7, 30'hfffffe8, 30'hffffea,
    30'h3ffffffc, 30'hfffffe9, 30'hfffffea, 30'h3ffffffd, 30'hfffffeb,
    30'hfffffec, 30'hfffffed, 30'hfffffee, 30'hfffffef, 30'hffffff0,
    30'hffffff1, 30'hffffff2, 30'h3ffffffe, 30'hffffff3, 30'hffffff4,
    30'hffffff5, 30'hffffff6, 30'hffffff7, 30'hffffff8, 30'hffffff9,
    30'hffffffa, 30'hffffffb, 30'h14, 30'h3f8, 30'h3f9,
    30'hffa, 30'h1ff9, 30'h15, 30'hf8, 30'h7fa,
    30'h3fa, 30'h3fb, 30'hf9, 30'h7fb, 30'hfa,
    30'h16, 30'h17, 30'h18, 30'h0, 30'h1,
    30'h2, 30'h19, 30'h1a, 30'h1b, 30'h1c,
    30'h1d, 30'h1e, 30'h1f, 30'h5c, 30'hfb,
    30'h7ffc, 30'h20, 30'hffb, 30'h3fc, 30'h1ffa,
    30'h21, 30'h5d, 30'h5e, 30'h5f, 30'h60,
    30'h61, 30'h62, 30'h63, 30'h64, 30'h65,
    30'h66, 30'h67, 30'h68, 30'h69, 30'h6a,
    30'h6b, 30'h6c, 30'h6d, 30'h6e, 30'h6f,
    30'h70, 30'h71, 30'h72, 30'hfc, 30'h73,
    30'hfd, 30'h1ffb, 30'h7fff0, 30'h1ffc, 30'h3ffc,
    30'h22, 30'h7ffd, 30'h3, 30'h23, 30'h4,
    30'h24, 30'h5, 30'h25, 30'h26, 30'h27,
    30'h6, 30'h74, 30'h75, 30'h28, 30'h29,
    30'h2a, 30'h7, 30'h2b, 30'h76, 30'h2c,
    30'h8, 30'h9, 30'h2d, 30'h77, 30'h78,
    30'h79, 30'h7a, 30'h7b, 30'h7ffe, 30'h7fc,
    30'h3ffd, 30'h1ffd, 30'hffffffc, 30'hfffe6, 30'h3fffd2,
    30'hfffe7, 30'hfffe8, 30'h3fffd3, 30'h3fffd4, 30'h3fffd5,
    30'h7fffd9, 30'h3fffd6, 30'h7fffda, 30'h7fffdb, 30'h7fffdc,
    30'h7fffdd, 30'h7fffde, 30'hffffeb, 30'h7fffdf, 30'hffffec,
    30'hffffed, 30'h3fffd7, 30'h7fffe0, 30'hffffee, 30'h7fffe1,
    30'h7fffe2, 30'h7fffe3, 30'h7fffe4, 30'h1fffdc, 30'h3fffd8,
    30'h7fffe5, 30'h3fffd9, 30'h7fffe6, 30'h7fffe7, 30'hffffef,
    30'h3fffda, 30'h1fffdd, 30'hfffe9, 30'h3fffdb, 30'h3fffdc,
    30'h7fffe8, 30'h7fffe9, 30'h1fffde, 30'h7fffea, 30'h3fffdd,
    30'h3fffde, 30'hfffff0, 30'h1fffdf, 30'h3fffdf, 30'h7fffeb,
    30'h7fffec, 30'h1fffe0, 30'h1fffe1, 30'h3fffe0, 30'h1fffe2,
    30'h7fffed, 30'h3fffe1, 30'h7fffee, 30'h7fffef, 30'hfffea,
    30'h3fffe2, 30'h3fffe3, 30'h3fffe4, 30'h7ffff0, 30'h3fffe5,
    30'h3fffe6, 30'h7ffff1, 30'h3ffffe0, 30'h3ffffe1, 30'hfffeb,
    30'h7fff1, 30'h3fffe7, 30'h7ffff2, 30'h3fffe8, 30'h1ffffec,
    30'h3ffffe2, 30'h3ffffe3, 30'h3ffffe4, 30'h7ffffde, 30'h7ffffdf,
    30'h3ffffe5, 30'hfffff1, 30'h1ffffed, 30'h7fff2, 30'h1fffe3,
    30'h3ffffe6, 30'h7ffffe0, 30'h7ffffe1, 30'h3ffffe7, 30'h7ffffe2,
    30'hfffff2, 30'h1fffe4, 30'h1fffe5, 30'h3ffffe8, 30'h3ffffe9,
    30'hffffffd, 30'h7ffffe3, 30'h7ffffe4, 30'h7ffffe5, 30'hfffec,
    30'hfffff3, 30'hfffed, 30'h1fffe6, 30'h3fffe9, 30'h1fffe7,
    30'h1fffe8, 30'h7ffff3, 30'h3fffea, 30'h3fffeb, 30'h1ffffee,
    30'h1ffffef, 30'hfffff4, 30'hfffff5, 30'h3ffffea, 30'h7ffff4,
    30'h3ffffeb, 30'h7ffffe6, 30'h3ffffec, 30'h3ffffed, 30'h7ffffe7,
    30'h7ffffe8, 30'h7ffffe9, 30'h7ffffea, 30'h7ffffeb, 30'hffffffe,
    30'h7ffffec, 30'h7ffffed, 30'h7ffffee, 30'h7ffffef, 30'h7fffff0,
    30'h3ffffee
  };

  localparam rom_len_t ROM_LEN = '{
    5'd13, 5'd23, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd24,
    5'd30, 5'd28, 5'd28, 5'd30, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
    5'd28, 5'd28, 5'd30, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
    5'd28, 5'd28, 5'd6, 5'd10, 5'd10, 5'd12, 5'd13, 5'd6, 5'd8, 5'd11,
    5'd10, 5'd10, 5'd8, 5'd11, 5'd8, 5'd6, 5'd6, 5'd6, 5'd5, 5'd5,
    5'd5, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6, 5'd7, 5'd8,
    5'd15, 5'd6, 5'd12, 5'd10, 5'd13, 5'd6, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd8, 5'd7,
    5'd8, 5'd13, 5'd19, 5'd13, 5'd14, 5'd6, 5'd15, 5'd5, 5'd6, 5'd5,
    5'd6, 5'd5, 5'd6, 5'd6, 5'd6, 5'd5, 5'd7, 5'd7, 5'd6, 5'd6,
    5'd6, 5'd5, 5'd6, 5'd7, 5'd6, 5'd5, 5'd5, 5'd6, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd15, 5'd11, 5'd14, 5'd13, 5'd28, 5'd20, 5'd22,
    5'd20, 5'd20, 5'd22, 5'd22, 5'd22, 5'd23, 5'd22, 5'd23, 5'd23, 5'd23,
    5'd23, 5'd23, 5'd24, 5'd23, 5'd24, 5'd24, 5'd22, 5'd23, 5'd24, 5'd23,
    5'd23, 5'd23, 5'd23, 5'd21, 5'd22, 5'd23, 5'd22, 5'd23, 5'd23, 5'd24,
    5'd22, 5'd21, 5'd20, 5'd22, 5'd22, 5'd23, 5'd23, 5'd21, 5'd23, 5'd22,
    5'd22, 5'd24, 5'd21, 5'd22, 5'd23, 5'd23, 5'd21, 5'd21, 5'd22, 5'd21,
    5'd23, 5'd22, 5'd23, 5'd23, 5'd20, 5'd22, 5'd22, 5'd22, 5'd23, 5'd22,
    5'd22, 5'd23, 5'd26, 5'd26, 5'd20, 5'd19, 5'd22, 5'd23, 5'd22, 5'd25,
    5'd26, 5'd26, 5'd26, 5'd27, 5'd27, 5'd26, 5'd24, 5'd25, 5'd19, 5'd21,
    5'd26, 5'd27, 5'd27, 5'd26, 5'd27, 5'd24, 5'd21, 5'd21, 5'd26, 5'd26,
    5'd28, 5'd27, 5'd27, 5'd27, 5'd20, 5'd24, 5'd20, 5'd21, 5'd22, 5'd21,
    5'd21, 5'd23, 5'd22, 5'd22, 5'd25, 5'd25, 5'd24, 5'd24, 5'd26, 5'd23,
    5'd26, 5'd27, 5'd26, 5'd26, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd28,
    5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd26
  };

  // lowest code of each length; zero where a length has no codes
  function automatic code_tab_t calc_first();
    code_tab_t f;
    logic [31:0] seen;
    f = '{default: '0};
    seen = '0;
    for (int s = 0; s < 256; s++) begin
      if (!seen[ROM_LEN[s]] || ROM_CODE[s] < f[ROM_LEN[s]]) begin
        f[ROM_LEN[s]] = ROM_CODE[s];
      end
      seen[ROM_LEN[s]] = 1'b1;
    end
    return f;
  endfunction

  // one past the highest code of each length; equals first where none
  function automatic code_tab_t calc_limit();
    code_tab_t f;
    code_tab_t l;
    f = calc_first();
    l = f;
    for (int s = 0; s < 256; s++) begin
      l[ROM_LEN[s]] = l[ROM_LEN[s]] + 30'd1;
    end
    return l;
  endfunction

  // number of symbols with a shorter code
  function automatic base_tab_t calc_base();
    base_tab_t b;
    b = '{default: '0};
    for (int s = 0; s < 256; s++) begin
      for (int l = 0; l < 32; l++) begin
        if (l > int'(ROM_LEN[s])) begin
          b[l] = b[l] + 9'd1;
        end
      end
    end
    return b;
  endfunction

  function automatic sym_tab_t calc_sorted();
    sym_tab_t  t;
    code_tab_t f;
    base_tab_t b;
    logic [CODE_W-1:0] off;
    logic [8:0] idx;
    t = '{default: '0};
    f = calc_first();
    b = calc_base();
    for (int s = 0; s < 256; s++) begin
      off = ROM_CODE[s] - f[ROM_LEN[s]];
      idx = b[ROM_LEN[s]] + off[8:0];
      t[idx[7:0]] = s[7:0];
    end
    return t;
  endfunction

  localparam code_tab_t FIRST_CODE = calc_first();
  localparam code_tab_t LIMIT_CODE = calc_limit();
  localparam base_tab_t BASE_IDX   = calc_base();
  localparam sym_tab_t  SORTED_SYM = calc_sorted();

endpackage

FILE: rtl/core/hpd_front.sv
// ----------------------------------------------------------------------------
// hpd_front
// Input beat acceptance and two-entry queue ahead of the bit decoder.
// ----------------------------------------------------------------------------
module hpd_front import hpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output fifo_head_t head,
  input  logic       pop
);

  in_item_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       do_pop;

  assign in_stall  = (count_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign head.vld  = (count_r != 2'd0);
  assign head.item = mem_r[rd_ptr_r];
  assign do_pop    = pop && head.vld;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

FILE: rtl/core/hpd_back.sv
// ----------------------------------------------------------------------------
// hpd_back
// Bit-serial canonical Huffman matcher, end-of-string check and result output.
// ----------------------------------------------------------------------------
module hpd_back import hpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  fifo_head_t head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  logic              running_r, running_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic [2:0]        bit_cnt_r, bit_cnt_nxt;
  logic              eos_r, eos_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [4:0]        len_r, len_nxt;
  logic              err_r, err_nxt;
  logic              hold_vld_r, hold_vld_nxt;
  out_item_t         hold_r, hold_nxt;
  logic              out_vld_r, out_vld_nxt;
  out_item_t         out_r, out_nxt;

  logic [CODE_W-1:0] ncode, off, post_code, pad_mask;
  logic [4:0]        nlen, post_len;
  logic [7:0]        idx;
  logic              hit, bad, done, post_err;
  logic              r1_vld, r2_vld;
  out_item_t         r1, r2;
  out_item_t         lst [3];
  logic [1:0]        n;
  logic              out_free, push, feasible, step;

  assign out_free  = !out_vld_r || !out_stall;
  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  // one decode step
  always_comb begin
    ncode     = {code_r[CODE_W-2:0], byte_r[7]};
    nlen      = len_r + 5'd1;
    hit       = (ncode >= FIRST_CODE[nlen]) && (ncode < LIMIT_CODE[nlen]);
    off       = ncode - FIRST_CODE[nlen];
    idx       = BASE_IDX[nlen][7:0] + off[7:0];
    bad       = !hit && (nlen == MAX_LEN);
    r1_vld    = 1'b0;
    r1        = '0;
    r2_vld    = 1'b0;
    r2        = '0;
    post_code = ncode;
    post_len  = nlen;
    post_err  = err_r;
    done      = 1'b0;
    if (err_r) begin
      post_code = code_r;
      post_len  = len_r;
      done      = 1'b1;
      if (eos_r) begin
        r2_vld    = 1'b1;
        r2.status = ST_BAD_CODE;
      end
    end else begin
      if (hit) begin
        r1_vld    = 1'b1;
        r1.symbol = SORTED_SYM[idx];
        r1.status = ST_SYMBOL;
        post_code = '0;
        post_len  = '0;
      end else if (bad) begin
        r1_vld    = 1'b1;
        r1.status = ST_BAD_CODE;
        post_code = '0;
        post_len  = '0;
        post_err  = 1'b1;
      end
      done = bad || (bit_cnt_r == 3'd7);
      if (done && eos_r && !bad) begin
        r2_vld = 1'b1;
        if (post_len == 5'd0) begin
          r2.status = ST_END_OK;
        end else if (post_len > PAD_MAX || post_code != pad_mask) begin
          r2.status = ST_BAD_PAD;
        end else begin
          r2.status = ST_END_OK;
        end
      end
    end
  end

  assign pad_mask = (30'd1 << post_len) - 30'd1;

  // results of this step queued behind the held one
  always_comb begin
    lst[0] = '0;
    lst[1] = '0;
    lst[2] = '0;
    n      = 2'd0;
    if (hold_vld_r) begin
      lst[n] = hold_r;
      n      = n + 2'd1;
    end
    if (running_r && r1_vld) begin
      lst[n] = r1;
      n      = n + 2'd1;
    end
    if (running_r && r2_vld) begin
      lst[n] = r2;
      n      = n + 2'd1;
    end
    if (running_r && done && n != 2'd0) begin
      lst[n - 2'd1].last = 1'b1;
    end
  end

  always_comb begin
    push         = out_free && (n != 2'd0) && (n >= 2'd2 || lst[0].last);
    feasible     = (n - {1'b0, push}) <= 2'd1;
    step         = running_r && feasible;
    hold_vld_nxt = hold_vld_r;
    hold_nxt     = hold_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r && out_stall;
    if (step || !running_r) begin
      if (push) begin
        out_nxt     = lst[0];
        out_vld_nxt = 1'b1;
      end
      if ((n - {1'b0, push}) == 2'd1) begin
        hold_vld_nxt = 1'b1;
        hold_nxt     = lst[n - 2'd1];
      end else begin
        hold_vld_nxt = 1'b0;
      end
    end else if (out_free && hold_vld_r && (hold_r.last || n == 2'd3)) begin
      out_nxt      = hold_r;
      out_vld_nxt  = 1'b1;
      hold_vld_nxt = 1'b0;
    end
  end

  // decoder state and byte loading
  always_comb begin
    pop         = !running_r || (step && done);
    running_nxt = running_r;
    byte_nxt    = byte_r;
    bit_cnt_nxt = bit_cnt_r;
    eos_nxt     = eos_r;
    code_nxt    = code_r;
    len_nxt     = len_r;
    err_nxt     = err_r;
    if (step) begin
      byte_nxt    = {byte_r[6:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r + 3'd1;
      code_nxt    = post_code;
      len_nxt     = post_len;
      err_nxt     = post_err;
      if (done && eos_r) begin
        code_nxt = '0;
        len_nxt  = '0;
        err_nxt  = 1'b0;
      end
    end
    if (pop) begin
      running_nxt = head.vld;
      byte_nxt    = head.item.code_byte;
      eos_nxt     = head.item.end_of_string;
      bit_cnt_nxt = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r  <= 1'b0;
      code_r     <= '0;
      len_r      <= '0;
      err_r      <= 1'b0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      running_r  <= running_nxt;
      code_r     <= code_nxt;
      len_r      <= len_nxt;
      err_r      <= err_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r    <= byte_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    eos_r     <= eos_nxt;
    hold_r    <= hold_nxt;
    out_r     <= out_nxt;
  end

endmodule

FILE: rtl/core/hpack_huffman_decoder.sv
// ----------------------------------------------------------------------------
// hpack_huffman_decoder
// HPACK string literal Huffman decoder, one coded bit per clock when not stalled.
// ----------------------------------------------------------------------------
// Coded bytes enter a two-entry queue and are decoded one bit per cycle, most
// significant bit first, while out_stall does not hold results back; a byte
// after an error is dropped undecoded. The bit-serial matcher sets this rate.
// Each symbol comes out as a status 0 beat; the end byte of a string adds a
// status beat (1 clean, 2 invalid code, 3 bad padding), and last marks the
// final beat a byte causes. One held result plus an output register let
// decoding run on while a finished beat waits on out_stall.
module hpack_huffman_decoder import hpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  fifo_head_t head;
  logic       pop;

  hpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  hpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the HPACK Huffman decoder: coded byte beats are driven with random
// gaps, decoded symbol and status beats are checked against a local decoder
// built on the package code table.
// ----------------------------------------------------------------------------
module tb_top;
  import hpd_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  hpack_huffman_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  in_item_t  byte_q[$];
  out_item_t expected_q[$];
  int        err_count;
  int        sent_count;
  int        got_count;
  int        sym_count;
  int        end_count[4];
  bit        hold_long;
  bit        wait_drain;

  logic [29:0] cur_code = '0;
  logic [4:0]  cur_len = '0;
  bit          cur_err = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("Regression FAIL");
    $finish;
  end

  function automatic int find_symbol(logic [29:0] c, logic [4:0] l);
    for (int s = 0; s < 256; s++) begin
      if (ROM_LEN[s] == l && ROM_CODE[s] == c) return s;
    end
    return -1;
  endfunction

  task automatic decode_byte(in_item_t it);
    out_item_t r[$];
    out_item_t o;
    bit        now_err;
    int        s;
    now_err = 0;
    if (!cur_err) begin
      for (int b = 7; b >= 0; b--) begin
        cur_code = {cur_code[28:0], it.code_byte[b]};
        cur_len++;
        s = find_symbol(cur_code, cur_len);
        if (s >= 0) begin
          o = '{symbol: s[7:0], status: ST_SYMBOL, last: 1'b0};
          r.insert(r.size(), o);
          cur_code = '0;
          cur_len = '0;
        end else if (cur_len >= MAX_LEN) begin
          o = '{symbol: 8'd0, status: ST_BAD_CODE, last: 1'b0};
          r.insert(r.size(), o);
          cur_code = '0;
          cur_len = '0;
          cur_err = 1;
          now_err = 1;
          break;
        end
      end
    end
    if (it.end_of_string) begin
      o = '{symbol: 8'd0, status: ST_END_OK, last: 1'b0};
      if (cur_err) o.status = ST_BAD_CODE;
      else if (cur_len != 0 && (cur_len > PAD_MAX ||
               cur_code != ((30'd1 << cur_len) - 30'd1))) o.status = ST_BAD_PAD;
      if (!(cur_err && now_err)) r.insert(r.size(), o);
      cur_code = '0;
      cur_len = '0;
      cur_err = 0;
    end
    if (r.size() > 0) r[r.size()-1].last = 1'b1;
    foreach (r[i]) expected_q.insert(expected_q.size(), r[i]);
  endtask

  task automatic report_mismatch(string msg);
    err_count++;
    $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  task automatic add_byte(logic [7:0] b, logic e);
    in_item_t it;
    it.code_byte     = b;
    it.end_of_string = e;
    byte_q.insert(byte_q.size(), it);
  endtask

  // the code of symbol s, appended to a bit buffer
  logic [1023:0] bitbuf;
  int            bitcnt;

  task automatic put_sym(int s);
    for (int i = int'(ROM_LEN[s]) - 1; i >= 0; i--) begin
      bitbuf[1023 - bitcnt] = ROM_CODE[s][i];
      bitcnt++;
    end
  endtask

  // mode 0 good pad, 1 long pad, 2 zero pad, 3 EOS inside
  task automatic queue_string(int nsym, int mode);
    int      nb;
    int      s;
    bitbuf = '0;
    bitcnt = 0;
    for (int k = 0; k < nsym; k++) begin
      s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(32, 126);
      put_sym(s);
      if (mode == 3 && k == nsym / 2) begin
        for (int i = 0; i < 30; i++) begin
          bitbuf[1023 - bitcnt] = 1'b1;
          bitcnt++;
        end
      end
    end
    if (mode == 1) begin
      for (int i = 0; i < 8; i++) begin
        bitbuf[1023 - bitcnt] = 1'b1;
        bitcnt++;
      end
    end
    nb = (bitcnt + 7) / 8;
    for (int i = bitcnt; i < nb * 8; i++) bitbuf[1023 - i] = (mode != 2);
    if (nb == 0) nb = 1;
    for (int i = 0; i < nb; i++) begin
      add_byte(bitbuf[1023 - 8*i -: 8], (i == nb - 1));
    end
  endtask

  int drv_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
      drv_gap  <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        decode_byte(in_item);
        sent_count++;
      end
      if (drv_gap > 0) begin
        drv_gap  <= drv_gap - 1;
        in_valid <= 1'b0;
      end else if (byte_q.size() > 0 && !(wait_drain && expected_q.size() > 0)) begin
        in_item  <= byte_q.pop_front();
        in_valid <= 1'b1;
        drv_gap  <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  int mon_gap;
  int hold_cnt;
  out_item_t got;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      mon_gap   <= 0;
      hold_cnt  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = out_item;
        got_count++;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat %p", got));
        end else begin
          if (got.symbol !== expected_q[0].symbol)
            report_mismatch($sformatf("symbol %h exp %h", got.symbol, expected_q[0].symbol));
          if (got.status !== expected_q[0].status)
            report_mismatch($sformatf("status %0d exp %0d", got.status, expected_q[0].status));
          if (got.last !== expected_q[0].last)
            report_mismatch($sformatf("last %b exp %b", got.last, expected_q[0].last));
          if (expected_q[0].status == ST_SYMBOL) sym_count++;
          else end_count[expected_q[0].status]++;
          void'(expected_q.pop_front());
        end
      end
      if (hold_long && hold_cnt == 0) begin
        hold_cnt  <= 400;
        out_stall <= 1'b1;
      end else if (hold_cnt > 1) begin
        hold_cnt <= hold_cnt - 1;
      end else if (hold_cnt == 1) begin
        hold_cnt  <= -1;
        out_stall <= 1'b0;
      end else if (mon_gap > 0) begin
        mon_gap   <= mon_gap - 1;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall) begin
        mon_gap   <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int wait_cnt;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, a clean string, padding faults, EOS path
    add_byte(8'hff, 1'b1);
    add_byte(8'h00, 1'b1);
    add_byte(8'hff, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(8'hfc, 1'b1);
    add_byte(8'hff, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'h07, 1'b1);
    add_byte(8'h01, 1'b1);
    queue_string(3, 0);
    queue_string(2, 1);
    queue_string(2, 2);
    queue_string(1, 3);

    wait (byte_q.size() == 0);
    wait_drain = 1;
    queue_string(4, 0);
    wait (byte_q.size() == 0);
    wait_drain = 0;

    while (sent_count < 450) begin
      case ($urandom_range(0, 9))
        0:       add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        1:       queue_string($urandom_range(0, 6), $urandom_range(1, 3));
        default: queue_string($urandom_range(1, 8), 0);
      endcase
      if (sent_count > 200 && !hold_long) hold_long = 1;
      wait (byte_q.size() < 4);
    end
    wait (byte_q.size() == 0);
    wait_cnt = 0;
    while ((in_valid || expected_q.size() > 0) && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (40) @(posedge clk);
    $display("bytes %0d, beats %0d, symbols %0d", sent_count, got_count, sym_count);
    $display("ends: clean %0d, bad code %0d, bad pad %0d",
             end_count[1], end_count[2], end_count[3]);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("errors %0d, left over %0d", err_count, expected_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
